### src/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// shared types, sizes and codes for the sorted list store
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [31:0] data_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage

### src/sorted_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// bounded sorted store of signed 32-bit values held in a chain of cells
// ----------------------------------------------------------------------------
// usage:
//  a transaction is taken at a rising edge with start high and busy low;
//  busy stays low, so one command can be issued every cycle.
//  command selects insert, remove or read; value and index go with it.
//  each cell compares its entry with value in parallel, the flags ripple
//  along the chain, and every cell loads its own entry, its left or right
//  neighbor's entry or value at the same edge.
//  the result appears on the cycle after acceptance with done high for
//  exactly one cycle; the receiver cannot stall, so each result must be
//  taken in that cycle. a new command may be accepted in the same cycle
//  that the previous result is shown.
//  every result carries count, head_value, tail_value and empty_res as they
//  stand after the command.
//  reset clears the count and the result strobe; entry contents are left
//  as they are and are only read once written.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  sli_pkg::data_t     value,
	input  logic [3:0]         index,
	output logic               done,
	output logic               ok,
	output logic [2:0]         status,
	output sli_pkg::data_t     read_value,
	output logic [4:0]         count,
	output sli_pkg::data_t     head_value,
	output sli_pkg::data_t     tail_value,
	output logic               empty_res
);
	import sli_pkg::*;

	cnt_t      count_q;
	cnt_t      count_d;
	cell_ctl_t ctl;
	logic      full;
	logic      found;
	logic      accept;

	data_t cell_entry [CAPACITY];
	data_t cell_nxt   [CAPACITY];
	logic  cell_after [CAPACITY];
	logic  cell_past  [CAPACITY];
	logic  cell_valid [CAPACITY];

	logic    done_q;
	logic    ok_q;
	status_t status_q;
	data_t   read_q;
	cnt_t    count_out_q;
	data_t   head_q;
	data_t   tail_q;
	logic    empty_q;

	logic    ok_d;
	status_t status_d;
	data_t   read_d;
	data_t   head_d;
	data_t   tail_d;
	data_t   rd_mux;
	data_t   tail_mux;

	assign accept = start && !busy;
	assign busy   = 1'b0;
	assign full   = (count_q >= cnt_t'(CAPACITY));
	assign found  = cell_past[CAPACITY-1];

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			assign cell_valid[gi] = (32'(count_q) > gi);
			if (gi == 0) begin : g_first
				sli_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.val        (value),
					.valid      (cell_valid[gi]),
					.prev_entry (value),
					.prev_after (1'b0),
					.prev_past  (1'b0),
					.next_entry (cell_entry[(gi + 1) % CAPACITY]),
					.entry      (cell_entry[gi]),
					.entry_nxt  (cell_nxt[gi]),
					.after      (cell_after[gi]),
					.past       (cell_past[gi])
				);
			end else if (gi == CAPACITY - 1) begin : g_last
				sli_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.val        (value),
					.valid      (cell_valid[gi]),
					.prev_entry (cell_entry[gi-1]),
					.prev_after (cell_after[gi-1]),
					.prev_past  (cell_past[gi-1]),
					.next_entry (cell_entry[gi]),
					.entry      (cell_entry[gi]),
					.entry_nxt  (cell_nxt[gi]),
					.after      (cell_after[gi]),
					.past       (cell_past[gi])
				);
			end else begin : g_mid
				sli_cell u_cell (
					.clk        (clk),
					.ctl        (ctl),
					.val        (value),
					.valid      (cell_valid[gi]),
					.prev_entry (cell_entry[gi-1]),
					.prev_after (cell_after[gi-1]),
					.prev_past  (cell_past[gi-1]),
					.next_entry (cell_entry[gi+1]),
					.entry      (cell_entry[gi]),
					.entry_nxt  (cell_nxt[gi]),
					.after      (cell_after[gi]),
					.past       (cell_past[gi])
				);
			end
		end
	endgenerate

	// command decode and status
	always_comb begin
		ctl      = '0;
		ok_d     = 1'b0;
		status_d = ST_OK;
		count_d  = count_q;
		case (cmd_t'(command))
			CMD_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.ins = accept;
					ok_d    = 1'b1;
					count_d = count_q + cnt_t'(1);
				end
			end
			CMD_REMOVE: begin
				ctl.rem = accept;
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOT_FOUND;
				end else begin
					ok_d    = 1'b1;
					count_d = count_q - cnt_t'(1);
				end
			end
			CMD_READ: begin
				if (32'(index) < 32'(count_q)) begin
					ok_d = 1'b1;
				end else begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	// one-hot selection of the read and tail slots
	always_comb begin
		rd_mux   = '0;
		tail_mux = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (32'(index) == i) begin
				rd_mux = rd_mux | cell_entry[i];
			end
			if (32'(count_d) == i + 1) begin
				tail_mux = tail_mux | cell_nxt[i];
			end
		end
	end

	assign read_d = (ok_d && cmd_t'(command) == CMD_READ) ? rd_mux : '0;
	assign head_d = (count_d != '0) ? cell_nxt[0] : '0;
	assign tail_d = (count_d != '0) ? tail_mux : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q        <= ok_d;
			status_q    <= status_d;
			read_q      <= read_d;
			count_out_q <= count_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			empty_q     <= (count_d == '0);
		end
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign status     = status_q;
	assign read_value = read_q;
	assign count      = 5'(count_out_q);
	assign head_value = head_q;
	assign tail_value = tail_q;
	assign empty_res  = empty_q;

endmodule

### src/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell
// one slot of the sorted chain: compares against the command value and
// shifts toward or away from its neighbors
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic               clk,
	input  sli_pkg::cell_ctl_t ctl,
	input  sli_pkg::data_t     val,
	input  logic               valid,
	input  sli_pkg::data_t     prev_entry,
	input  logic               prev_after,
	input  logic               prev_past,
	input  sli_pkg::data_t     next_entry,
	output sli_pkg::data_t     entry,
	output sli_pkg::data_t     entry_nxt,
	output logic               after,
	output logic               past
);
	import sli_pkg::*;

	data_t entry_q;
	logic  gt;
	logic  match;

	assign gt    = valid && (entry_q > val);
	assign after = !valid || gt;
	assign match = valid && (entry_q == val);
	assign past  = prev_past || match;

	always_comb begin
		entry_nxt = entry_q;
		if (ctl.ins) begin
			if (after) begin
				entry_nxt = prev_after ? prev_entry : val;
			end
		end else if (ctl.rem) begin
			if (past) begin
				entry_nxt = next_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	assign entry = entry_q;

endmodule

### src/sli_checker.sv
// ----------------------------------------------------------------------------
// sli_checker
// port-level checks on the sorted list store, bound to the top level
// ----------------------------------------------------------------------------
module sli_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic [1:0]     command,
	input sli_pkg::data_t value,
	input logic [3:0]     index,
	input logic           done,
	input logic           ok,
	input logic [2:0]     status,
	input sli_pkg::data_t read_value,
	input logic [4:0]     count,
	input sli_pkg::data_t head_value,
	input sli_pkg::data_t tail_value,
	input logic           empty_res
);
	import sli_pkg::*;

	// every result follows an accepted transaction
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a transaction");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ok == (status == ST_OK)))
		else $error("ok and status disagree");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (empty_res == (count == 5'd0)))
		else $error("empty flag and count disagree");

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !empty_res) |-> (head_value <= tail_value))
		else $error("head above tail");

	// a failed transaction leaves the count alone
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(done) && !ok) |-> (count == $past(count)))
		else $error("count changed on a failed transaction");

endmodule

bind sorted_list_insert_remove_top sli_checker u_sli_checker (.*);
